/* sv/multi_waveform_oscillator_vibrato_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the oscillator core
// Shared wrappers for concurrent checks on the core clock
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_VIBRATO_CORE_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_VIBRATO_CORE_DEFINES_SVH

// check with synchronous reset masking
`define MWOV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define MWOV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mwov_pkg.sv */
// ----------------------------------------------------------------------------
// mwov_pkg
// Constants and elaboration-time table functions for the oscillator core
// ----------------------------------------------------------------------------
package mwov_pkg;

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [31:0] TwoPiQ30  = 32'd683565276;
  localparam logic [31:0] VibK      = 32'd170891319;
  localparam logic [15:0] UnitQ14   = 16'd16384;

  // quarter-wave sine magnitude in q1.14 at entry k of a 2^qbits quarter
  function automatic logic [14:0] quarter_mag(input int k, input int qbits);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] mag;
    a = 64'(k) << (30 - qbits);
    x = (a * HalfPiQ30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30One;
    for (int i = 0; i < 5; i++) begin
      p = (x2 * t) >> 30;
      unique case (i)
        0: p = p / 64'd110;
        1: p = p / 64'd72;
        2: p = p / 64'd42;
        3: p = p / 64'd20;
        default: p = p / 64'd6;
      endcase
      t = Q30One - p;
    end
    mag = (((x * t) >> 30) + 64'd32768) >> 16;
    if (mag > 64'(UnitQ14)) begin
      mag = 64'(UnitQ14);
    end
    return mag[14:0];
  endfunction

  // ceil(2^32 / n) by shift-subtract long division
  function automatic logic [32:0] recip(input int n);
    logic [33:0] num;
    logic [33:0] rem;
    logic [33:0] den;
    logic [32:0] q;
    num = (34'd1 << 32) + 34'(n) - 34'd1;
    den = 34'(n);
    rem = '0;
    q = '0;
    if (n > 0) begin
      for (int i = 33; i >= 0; i--) begin
        rem = {rem[32:0], num[i]};
        if (rem >= den) begin
          rem = rem - den;
          if (i < 33) begin
            q[i] = 1'b1;
          end
        end
      end
    end
    return q;
  endfunction

endpackage

/* sv/mwov_if.sv */
// ----------------------------------------------------------------------------
// mwov channel interfaces
// Valid/ready channels for oscillator request beats and sample beats
// ----------------------------------------------------------------------------
interface mwov_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] time_ticks;
  logic [19:0] tone_freq;
  logic [15:0] vibrato_freq;
  logic [15:0] vibrato_depth;

  modport source (output valid, func, time_ticks, tone_freq, vibrato_freq, vibrato_depth,
                  input ready);
  modport sink (input valid, func, time_ticks, tone_freq, vibrato_freq, vibrato_depth,
                output ready);
endinterface

interface mwov_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

/* sv/mwov_sine_rom.sv */
// ----------------------------------------------------------------------------
// mwov_sine_rom
// Quarter-wave sine table with symmetry folding, q2.14 signed output
// ----------------------------------------------------------------------------
module mwov_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic [31:0]        phase,
  output logic signed [15:0] sine
);
  import mwov_pkg::*;

  localparam int QBits = TABLE_BITS - 2;
  localparam int QDepth = (1 << QBits) + 1;

  logic [14:0]           qtab [QDepth];
  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [QBits-1:0]      r;
  logic [QBits:0]        a;
  logic [14:0]           mag;

  for (genvar k = 0; k < QDepth; k++) begin : g_tab
    assign qtab[k] = quarter_mag(k, QBits);
  end

  assign idx  = phase[31 -: TABLE_BITS];
  assign quad = idx[TABLE_BITS-1 -: 2];
  assign r    = idx[QBits-1:0];
  assign a    = quad[0] ? ((QBits+1)'(1) << QBits) - {1'b0, r} : {1'b0, r};
  assign mag  = qtab[a];
  assign sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

/* sv/multi_waveform_oscillator_vibrato_core.sv */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_vibrato_core
// Sine, square, triangle and additive saw oscillator with sine vibrato
// Processes one request at a time; the saw loops over its terms with a multiply and
// an accumulate step each. A new beat is accepted only in idle, after the previous
// sample beat is taken; a single shared multiplier is reused for every product and saw term.
// Reset: synchronous, returns to idle, drops any pending sample, saw_terms = 49.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_vibrato_core_defines.svh"

module multi_waveform_oscillator_vibrato_core #(
  parameter int MAX_TERMS = 64,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [5:0]    cfg_wr_data,
  mwov_item_if.sink     item,
  mwov_result_if.source result
);
  import mwov_pkg::*;

  localparam int NW = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;
  localparam int CapMax = MAX_TERMS - 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CAR  = 4'd1;
  localparam logic [3:0] S_VIB  = 4'd2;
  localparam logic [3:0] S_DF   = 4'd3;
  localparam logic [3:0] S_SV   = 4'd4;
  localparam logic [3:0] S_M    = 4'd5;
  localparam logic [3:0] S_HI   = 4'd6;
  localparam logic [3:0] S_LO   = 4'd7;
  localparam logic [3:0] S_PH   = 4'd8;
  localparam logic [3:0] S_FN   = 4'd9;
  localparam logic [3:0] S_SM   = 4'd10;
  localparam logic [3:0] S_SA   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_SAT  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  localparam logic [1:0] F_SINE = 2'd0;
  localparam logic [1:0] F_SQR  = 2'd1;
  localparam logic [1:0] F_TRI  = 2'd2;
  localparam logic [1:0] F_SAW  = 2'd3;

  logic [3:0]         state;
  logic [5:0]         saw_terms;
  logic [1:0]         func;
  logic [31:0]        t;
  logic [19:0]        f;
  logic [15:0]        fv;
  logic [15:0]        d;
  logic [31:0]        carrier;
  logic [31:0]        vib;
  logic [35:0]        df;
  logic [14:0]        sv_mag;
  logic               sv_neg;
  logic [31:0]        m_lo;
  logic [31:0]        off_hi;
  logic [31:0]        phase;
  logic [31:0]        p;
  logic [NW-1:0]      n;
  logic               q_neg;
  logic signed [30:0] acc;
  logic [63:0]        prod;
  logic signed [15:0] sample;

  logic [NW-1:0]      terms_cap;
  logic [32:0]        rtab [MAX_TERMS];
  logic [35:0]        mul_a;
  logic [32:0]        mul_b;
  logic [31:0]        rom_ph;
  logic signed [15:0] sine;
  logic [14:0]        sine_mag;
  logic [31:0]        off;
  logic [1:0]         quad;
  logic [30:0]        tri_a;
  logic [14:0]        tri_mag;
  logic [24:0]        q;
  logic [29:0]        acc_mag;
  logic [23:0]        saw_mag;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_recip
    assign rtab[k] = recip(k);
  end

  mwov_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .phase(rom_ph),
    .sine (sine)
  );

  assign terms_cap = (32'(saw_terms) > CapMax) ? NW'(CapMax) : NW'(saw_terms);
  assign sine_mag  = sine[15] ? 15'(-sine) : sine[14:0];
  assign off       = off_hi + prod[63:32];
  assign quad      = phase[31:30];
  assign tri_a     = quad[0] ? 31'h4000_0000 - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
  assign tri_mag   = tri_a[30:16];
  assign q         = prod[56:32];
  assign acc_mag   = acc[30] ? 30'(-acc) : acc[29:0];
  assign saw_mag   = 24'((prod + (64'd1 << 39)) >> 40);

  always_comb begin
    unique case (state)
      S_SV:    rom_ph = vib;
      S_FN:    rom_ph = phase;
      default: rom_ph = p;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CAR: begin
        mul_a = 36'(f);
        mul_b = 33'(t);
      end
      S_VIB: begin
        mul_a = 36'(fv);
        mul_b = 33'(t);
      end
      S_DF: begin
        mul_a = 36'(d);
        mul_b = 33'(f);
      end
      S_M: begin
        mul_a = df;
        mul_b = 33'(sv_mag);
      end
      S_HI: begin
        mul_a = 36'(prod[50:32]);
        mul_b = 33'(VibK);
      end
      S_LO: begin
        mul_a = 36'(m_lo);
        mul_b = 33'(VibK);
      end
      S_SM: begin
        mul_a = 36'({sine_mag, 10'b0});
        mul_b = rtab[n];
      end
      S_FIN: begin
        mul_a = 36'(acc_mag);
        mul_b = 33'(TwoPiQ30);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saw_terms <= 6'd49;
    end else if (cfg_wr_en) begin
      saw_terms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            func  <= item.func;
            t     <= item.time_ticks;
            f     <= item.tone_freq;
            fv    <= item.vibrato_freq;
            d     <= item.vibrato_depth;
            state <= S_CAR;
          end
        end
        S_CAR: state <= S_VIB;
        S_VIB: begin
          carrier <= {prod[19:0], 12'b0};
          state   <= S_DF;
        end
        S_DF: begin
          vib   <= {prod[23:0], 8'b0};
          state <= S_SV;
        end
        S_SV: begin
          sv_mag <= sine_mag;
          sv_neg <= sine[15];
          df     <= prod[35:0];
          state  <= S_M;
        end
        S_M: state <= S_HI;
        S_HI: begin
          m_lo  <= prod[31:0];
          state <= S_LO;
        end
        S_LO: begin
          off_hi <= prod[31:0];
          state  <= S_PH;
        end
        S_PH: begin
          phase <= carrier + (sv_neg ? 32'd0 - off : off);
          state <= S_FN;
        end
        S_FN: begin
          unique case (func)
            F_SINE: begin
              sample <= sine;
              state  <= S_OUT;
            end
            F_SQR: begin
              sample <= (sine > 16'sd0) ? $signed(UnitQ14) : -$signed(UnitQ14);
              state  <= S_OUT;
            end
            F_TRI: begin
              sample <= quad[1] ? -$signed({1'b0, tri_mag}) : $signed({1'b0, tri_mag});
              state  <= S_OUT;
            end
            F_SAW: begin
              p   <= phase;
              n   <= NW'(1);
              acc <= '0;
              if (terms_cap == '0) begin
                sample <= '0;
                state  <= S_OUT;
              end else begin
                state <= S_SM;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_SM: begin
          q_neg <= sine[15];
          p     <= p + phase;
          state <= S_SA;
        end
        S_SA: begin
          acc <= q_neg ? acc - 31'(q) : acc + 31'(q);
          if (n == terms_cap) begin
            state <= S_FIN;
          end else begin
            n     <= n + NW'(1);
            state <= S_SM;
          end
        end
        S_FIN: state <= S_SAT;
        S_SAT: begin
          if (acc[30]) begin
            sample <= (saw_mag > 24'd32768) ? -16'sd32768 : -$signed(16'(saw_mag));
          end else begin
            sample <= (saw_mag > 24'd32767) ? 16'sd32767 : $signed(16'(saw_mag));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready    = (state == S_IDLE);
  assign result.valid  = (state == S_OUT);
  assign result.sample = sample;

  `MWOV_ASSERT(a_no_overlap, clk, rst, !(item.ready && result.valid), "ready while sample pending")
  `MWOV_ASSERT(a_term_range, clk, rst, (state == S_SM) |-> (n != '0) && (n <= terms_cap),
    "saw term index out of range")
  `MWOV_ASSERT(a_saw_end, clk, rst, (state == S_SA) && (n == terms_cap) |=> (state == S_FIN),
    "saw loop did not finish")
  `MWOV_ASSERT(a_accept_start, clk, rst, item.valid && item.ready |=> (state == S_CAR),
    "accepted beat did not start")
  `MWOV_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE),
    "not idle after reset")

endmodule

/* sim/osc_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osc_scoreboard
// Predicts oscillator samples from accepted request beats and checks the
// sample beats in order against them
// ----------------------------------------------------------------------------
class osc_scoreboard;
  logic signed [15:0] sample_q[$];
  int                 errors;
  int                 sine_tab[1024];
  logic [5:0]         saw_terms;

  function new();
    logic [63:0] a, x, x2, t, mag;
    logic [31:0] ph, r;
    int          quad;
    errors = 0;
    saw_terms = 6'd49;
    for (int k = 0; k < 1024; k++) begin
      ph = 32'(k) << 22;
      quad = ph[31:30];
      r = {2'b00, ph[29:0]};
      a = quad[0] ? (64'd1073741824 - 64'(r)) : 64'(r);
      x = (a * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t = 64'd1073741824;
      t = 64'd1073741824 - (((x2 * t) >> 30) / 110);
      t = 64'd1073741824 - (((x2 * t) >> 30) / 72);
      t = 64'd1073741824 - (((x2 * t) >> 30) / 42);
      t = 64'd1073741824 - (((x2 * t) >> 30) / 20);
      t = 64'd1073741824 - (((x2 * t) >> 30) / 6);
      mag = (((x * t) >> 30) + 64'd32768) >> 16;
      if (mag > 64'd16384) mag = 64'd16384;
      sine_tab[k] = quad[1] ? -int'(mag) : int'(mag);
    end
  endfunction

  function int sine_at(logic [31:0] ph);
    return sine_tab[ph[31:22]];
  endfunction

  function int saw_at(logic [31:0] ph);
    longint      acc;
    logic [63:0] mag;
    logic [31:0] p;
    acc = 0;
    for (int n = 1; n <= int'(saw_terms); n++) begin
      p = 32'(64'(n) * 64'(ph));
      acc += (longint'(sine_at(p)) * 1024) / n;
    end
    mag = 64'(acc < 0 ? -acc : acc);
    mag = (mag * 64'd683565276 + (64'd1 << 39)) >> 40;
    if (acc < 0) return mag > 64'd32768 ? -32768 : -int'(mag);
    return mag > 64'd32767 ? 32767 : int'(mag);
  endfunction

  function void note_request(logic [1:0] func, logic [31:0] tt, logic [19:0] f,
                             logic [15:0] fv, logic [15:0] d);
    logic [31:0]  carrier, vib, phase, off, r;
    logic [127:0] m;
    logic [63:0]  hi, lo;
    int           sv, s, q;
    carrier = 32'((64'(f) * 64'(tt)) << 12);
    vib = 32'((64'(fv) * 64'(tt)) << 8);
    sv = sine_at(vib);
    m = 128'(d) * 128'(f) * 128'(sv < 0 ? -sv : sv);
    hi = m[95:32];
    lo = m[31:0];
    off = 32'(hi * 64'd170891319 + ((lo * 64'd170891319) >> 32));
    if (sv < 0) off = 32'd0 - off;
    phase = carrier + off;
    case (func)
      2'd0: s = sine_at(phase);
      2'd1: s = sine_at(phase) > 0 ? 16384 : -16384;
      2'd2: begin
        q = phase[31:30];
        r = {2'b00, phase[29:0]};
        if (q[0]) r = 32'h4000_0000 - r;
        s = q[1] ? -int'(r >> 16) : int'(r >> 16);
      end
      default: s = saw_at(phase);
    endcase
    sample_q.push_back(16'(s));
  endfunction

  task report(string msg);
    $display("%s", msg);
    errors++;
  endtask

  task check_sample(logic signed [15:0] got);
    logic signed [15:0] exp_s;
    if (sample_q.size() == 0) begin
      report($sformatf("unexpected sample beat %0d", got));
      return;
    end
    exp_s = sample_q.pop_front();
    if (got !== exp_s) begin
      report($sformatf("sample mismatch: got %0d expected %0d", got, exp_s));
    end
  endtask
endclass

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed oscillator requests with idle bursts on both sides
// (not in the last phase), reprograms the saw term count between phases, and
// checks samples
module testbench;
  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;
  int         stalls_on;
  int         idle_cycles;
  osc_scoreboard board;

  mwov_item_if   item ();
  mwov_result_if result ();

  multi_waveform_oscillator_vibrato_core i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .item(item.sink), .result(result.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    item.valid = 1'b0;
    item.func = '0;
    item.time_ticks = '0;
    item.tone_freq = '0;
    item.vibrato_freq = '0;
    item.vibrato_depth = '0;
    result.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst = 1'b1;
    stalls_on = 1;
  end

  // sample side: check beats, random backpressure bursts
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      board.check_sample(result.sample);
    end
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        result.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result.ready = 1'b1;
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_request(logic [1:0] func, logic [31:0] tt, logic [19:0] f,
                              logic [15:0] fv, logic [15:0] d);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      item.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item.valid = 1'b1;
    item.func = func;
    item.time_ticks = tt;
    item.tone_freq = f;
    item.vibrato_freq = fv;
    item.vibrato_depth = d;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    board.note_request(func, tt, f, fv, d);
    @(negedge clk);
    item.valid = 1'b0;
  endtask

  task automatic drain_samples();
    while (board.sample_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_terms(logic [5:0] n);
    drain_samples();
    cfg_wr_en = 1'b1;
    cfg_wr_data = n;
    board.saw_terms = n;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_phase(int count, bit saw_heavy);
    logic [1:0] fn;
    for (int i = 0; i < count; i++) begin
      fn = saw_heavy ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) fn = 2'd3;
      case ($urandom_range(0, 3))
        0: send_request(fn, $urandom, 20'($urandom), 16'($urandom), 16'($urandom));
        1: send_request(fn, $urandom_range(0, 65535), 20'($urandom_range(0, 320000)),
                        16'($urandom_range(0, 4000)), 16'($urandom));
        2: send_request(fn, $urandom, 20'($urandom), 16'($urandom), 16'd0);
        default: send_request(fn, $urandom, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
      endcase
    end
  endtask

  initial begin
    logic [5:0] terms_set[6];
    board = new();
    terms_set = '{6'd49, 6'd0, 6'd63, 6'd1, 6'd7, 6'd20};
    repeat (12) @(negedge clk);
    rst = 1'b0;
    // directed
    for (int fn = 0; fn < 4; fn++) begin
      send_request(2'(fn), 32'd0, 20'd0, 16'd0, 16'd0);
      send_request(2'(fn), 32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
      send_request(2'(fn), 32'd16384, 20'd16, 16'd0, 16'd0);
      send_request(2'(fn), 32'h0001_0000, 20'd7040, 16'd1536, 16'h8000);
      send_request(2'(fn), 32'h1234_5678, 20'h55555, 16'hAAAA, 16'h5555);
    end
    for (int p = 0; p < 6; p++) begin
      write_terms(terms_set[p]);
      if (p == 5) stalls_on = 0;
      random_phase(p == 2 ? 60 : 190, p != 2);
      if (p == 3) drain_samples();
    end
    drain_samples();
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/mwov_pkg.sv
sv/mwov_if.sv
sv/mwov_sine_rom.sv
sv/multi_waveform_oscillator_vibrato_core.sv
sim/osc_scoreboard.sv
sim/testbench.sv
